FILE: hdl/bpc_pkg.sv
`timescale 1ns / 1ps

package bpc_pkg;

    localparam int unsigned CfgWidth  = 16;
    localparam int unsigned TimeWidth = 32;
    localparam int unsigned IdxWidth  = 2;

    typedef enum logic [IdxWidth-1:0] {
        CFG_DEBOUNCE  = 2'd0,
        CFG_LONG      = 2'd1,
        CFG_SHORT_MAX = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } t_event;

    typedef struct packed {
        logic [CfgWidth-1:0] debounce_ms;
        logic [CfgWidth-1:0] long_press_ms;
        logic [CfgWidth-1:0] short_press_max_ms;
    } t_cfg;

    localparam logic [CfgWidth-1:0] DebounceRst = 16'd50;
    localparam logic [CfgWidth-1:0] LongRst     = 16'd1000;
    localparam logic [CfgWidth-1:0] ShortMaxRst = 16'd500;

endpackage

FILE: hdl/bpc_cfg.sv
`timescale 1ns / 1ps

module bpc_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bpc_pkg::IdxWidth-1:0]     i_cfg_idx,
    input  logic [bpc_pkg::CfgWidth-1:0]     i_cfg_data,
    output bpc_pkg::t_cfg                    o_cfg
);

    bpc_pkg::t_cfg r_cfg;
    bpc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (bpc_pkg::t_cfg_idx'(i_cfg_idx))
                bpc_pkg::CFG_DEBOUNCE:  n_cfg.debounce_ms        = i_cfg_data;
                bpc_pkg::CFG_LONG:      n_cfg.long_press_ms      = i_cfg_data;
                bpc_pkg::CFG_SHORT_MAX: n_cfg.short_press_max_ms = i_cfg_data;
                default:                n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms        <= bpc_pkg::DebounceRst;
            r_cfg.long_press_ms      <= bpc_pkg::LongRst;
            r_cfg.short_press_max_ms <= bpc_pkg::ShortMaxRst;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hdl/bpc_core.sv
`timescale 1ns / 1ps

module bpc_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_pressed,
    input  logic [bpc_pkg::TimeWidth-1:0]     i_now_ms,
    input  bpc_pkg::t_cfg                     i_cfg,
    output bpc_pkg::t_event                   o_event
);

    logic                           r_last_level;
    logic [bpc_pkg::TimeWidth-1:0]  r_press_start;
    logic [bpc_pkg::TimeWidth-1:0]  r_release_time;
    logic                           r_held;
    logic                           r_long_fired;

    logic                           n_last_level;
    logic [bpc_pkg::TimeWidth-1:0]  n_press_start;
    logic [bpc_pkg::TimeWidth-1:0]  n_release_time;
    logic                           n_held;
    logic                           n_long_fired;

    logic [bpc_pkg::TimeWidth-1:0]  since_release;
    logic [bpc_pkg::TimeWidth-1:0]  since_press;
    logic [bpc_pkg::TimeWidth-1:0]  held_time;
    logic [bpc_pkg::TimeWidth-1:0]  debounce_ext;
    logic                           start;
    logic                           rel_ok;
    bpc_pkg::t_event                ev;

    assign since_release = i_now_ms - r_release_time;
    assign since_press   = i_now_ms - r_press_start;
    assign debounce_ext  = {{(bpc_pkg::TimeWidth-bpc_pkg::CfgWidth){1'b0}}, i_cfg.debounce_ms};
    assign start         = i_pressed && !r_last_level && (since_release > debounce_ext);
    // a press that starts on this sample has zero held time
    assign held_time     = start ? '0 : since_press;
    assign rel_ok        = !i_pressed && r_last_level && (since_press > debounce_ext);

    always_comb begin
        n_last_level   = i_pressed;
        n_press_start  = start ? i_now_ms : r_press_start;
        n_release_time = r_release_time;
        n_held         = r_held || start;
        n_long_fired   = start ? 1'b0 : r_long_fired;
        ev             = bpc_pkg::EV_NONE;

        if (n_held && !n_long_fired &&
            (held_time >= {{(bpc_pkg::TimeWidth-bpc_pkg::CfgWidth){1'b0}},
                           i_cfg.long_press_ms})) begin
            n_long_fired = 1'b1;
            ev           = bpc_pkg::EV_LONG;
        end

        if (rel_ok) begin
            n_release_time = i_now_ms;
            if (n_held && !n_long_fired &&
                (since_press < {{(bpc_pkg::TimeWidth-bpc_pkg::CfgWidth){1'b0}},
                                i_cfg.short_press_max_ms})) begin
                ev = bpc_pkg::EV_SHORT;
            end
            n_held = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level   <= 1'b0;
            r_press_start  <= '0;
            r_release_time <= '0;
            r_held         <= 1'b0;
            r_long_fired   <= 1'b0;
        end else if (i_en) begin
            r_last_level   <= n_last_level;
            r_press_start  <= n_press_start;
            r_release_time <= n_release_time;
            r_held         <= n_held;
            r_long_fired   <= n_long_fired;
        end
    end

    assign o_event = ev;

endmodule

FILE: hdl/button_press_classifier.sv
`timescale 1ns / 1ps

// Button press classifier.
// Input channel (i_valid/o_ready) carries one item per sample: the button
// level i_pressed and a wrapping millisecond timestamp i_now_ms.
// Output channel (o_valid/i_ready) returns exactly one item per input item,
// o_event_res: none, short press or long press.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 debounce, 1 long-press threshold, 2 short-press maximum); index 3
// is ignored. Write only while no item is in flight.
// An accepted item waits in the input register and is classified as it
// moves into the result register. Throughput is one item per cycle while
// the receiver keeps up; the press/release state is updated by the same
// edge that loads the result register, so the next sample sees it.
// Reset (synchronous, active low) restores the default thresholds and
// the released state and empties both stages.
// When the receiver stalls the result register holds; the input register
// still takes one more item, then o_ready drops until the output drains.
module button_press_classifier (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_pressed,
    input  logic [bpc_pkg::TimeWidth-1:0]  i_now_ms,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [1:0]                     o_event_res,
    input  logic                           i_cfg_we,
    input  logic [bpc_pkg::IdxWidth-1:0]   i_cfg_idx,
    input  logic [bpc_pkg::CfgWidth-1:0]   i_cfg_data
);

    logic                           r_in_valid;
    logic                           r_in_pressed;
    logic [bpc_pkg::TimeWidth-1:0]  r_in_now;
    logic                           r_out_valid;
    bpc_pkg::t_event                r_out_event;

    bpc_pkg::t_cfg                  cfg;
    bpc_pkg::t_event                ev;
    logic                           advance;
    logic                           in_take;

    assign advance = !r_out_valid || i_ready;
    assign o_ready = !r_in_valid || advance;
    assign in_take = i_valid && o_ready;

    bpc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bpc_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (r_in_valid && advance),
        .i_pressed (r_in_pressed),
        .i_now_ms  (r_in_now),
        .i_cfg     (cfg),
        .o_event   (ev)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_pressed <= i_pressed;
            r_in_now     <= i_now_ms;
        end
        if (advance && r_in_valid) begin
            r_out_event <= ev;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_event_res = r_out_event;

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int StallLimit = 4000;
    localparam int PhaseItems = 225;
    localparam logic [bpc_pkg::IdxWidth-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic        pressed;
        logic [31:0] now;
    } t_sample;

    logic                          i_clk;
    logic                          i_rst_n    = 1'b0;
    logic                          i_valid    = 1'b0;
    logic                          o_ready;
    logic                          i_pressed  = 1'b0;
    logic [bpc_pkg::TimeWidth-1:0] i_now_ms   = '0;
    logic                          o_valid;
    logic                          i_ready    = 1'b0;
    logic [1:0]                    o_event_res;
    logic                          i_cfg_we   = 1'b0;
    logic [bpc_pkg::IdxWidth-1:0]  i_cfg_idx  = '0;
    logic [bpc_pkg::CfgWidth-1:0]  i_cfg_data = '0;

    button_press_classifier u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_pressed   (i_pressed),
        .i_now_ms    (i_now_ms),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_event_res (o_event_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    t_sample          sample_q[$];
    bpc_pkg::t_event  event_q[$];
    t_sample          next_sample;
    bpc_pkg::t_event  want_ev;
    int               err_count   = 0;
    int               quiet_cycles = 0;
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;
    int               n_queued;
    logic [31:0]      cur_ms;

    // mirror of the block's thresholds and press/release tracking
    bpc_pkg::t_cfg cfg_now = '{bpc_pkg::DebounceRst, bpc_pkg::LongRst, bpc_pkg::ShortMaxRst};
    logic          prev_level  = 1'b0;
    logic [31:0]   press_start = '0;
    logic [31:0]   release_at  = '0;
    logic          is_held     = 1'b0;
    logic          long_done   = 1'b0;

    function automatic bpc_pkg::t_event classify(input logic lvl, input logic [31:0] now);
        bpc_pkg::t_event ev;
        logic [31:0]     since_rel;
        logic [31:0]     dur;
        ev = bpc_pkg::EV_NONE;
        since_rel = now - release_at;
        if (lvl && !prev_level && since_rel > {16'd0, cfg_now.debounce_ms}) begin
            press_start = now;
            is_held = 1'b1;
            long_done = 1'b0;
        end
        dur = now - press_start;
        if (is_held && !long_done && dur >= {16'd0, cfg_now.long_press_ms}) begin
            long_done = 1'b1;
            ev = bpc_pkg::EV_LONG;
        end
        if (!lvl && prev_level && dur > {16'd0, cfg_now.debounce_ms}) begin
            release_at = now;
            if (is_held && !long_done && dur < {16'd0, cfg_now.short_press_max_ms})
                ev = bpc_pkg::EV_SHORT;
            is_held = 1'b0;
        end
        prev_level = lvl;
        return ev;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // input side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                event_q.push_back(classify(i_pressed, i_now_ms));
            if (!i_valid || o_ready) begin
                if (sample_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_sample = sample_q.pop_front();
                    i_valid   <= 1'b1;
                    i_pressed <= next_sample.pressed;
                    i_now_ms  <= next_sample.now;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // output side
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (i_rst_n && o_valid && i_ready) begin
            if (event_q.size() == 0) begin
                $display("%0t: unexpected item, event_res %0d", $time, o_event_res);
                err_count++;
            end else begin
                want_ev = event_q.pop_front();
                if (o_event_res !== want_ev) begin
                    $display("%0t: event_res mismatch, expected %0d actual %0d",
                             $time, want_ev, o_event_res);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("%0t: no progress for %0d cycles", $time, StallLimit);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic add_sample(input logic lvl, input logic [31:0] t);
        t_sample s;
        s.pressed = lvl;
        s.now = t;
        sample_q.push_back(s);
        n_queued++;
    endtask

    task automatic cfg_write(input logic [bpc_pkg::IdxWidth-1:0] idx,
                             input logic [bpc_pkg::CfgWidth-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            bpc_pkg::CFG_DEBOUNCE:  cfg_now.debounce_ms = val;
            bpc_pkg::CFG_LONG:      cfg_now.long_press_ms = val;
            bpc_pkg::CFG_SHORT_MAX: cfg_now.short_press_max_ms = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (sample_q.size() != 0 || i_valid || event_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] near(input logic [31:0] b);
        case ($urandom_range(0, 4))
            0:       return b - 1;
            1:       return b;
            2:       return b + 1;
            3:       return $urandom_range(0, 2 * b + 10);
            default: return $urandom_range(0, 300);
        endcase
    endfunction

    // one press: release gap (optional low sample), rising edge, optional bounce, held samples, release, low samples
    task automatic gen_press();
        logic [31:0] gap;
        logic [31:0] dur;
        logic [31:0] t0;
        logic [31:0] b;
        int          k;
        gap = near(32'(cfg_now.debounce_ms));
        t0 = cur_ms + gap;
        if ($urandom_range(0, 3) == 0)
            add_sample(1'b0, cur_ms + gap / 2);
        add_sample(1'b1, t0);
        case ($urandom_range(0, 4))
            0:       dur = near(32'(cfg_now.debounce_ms));
            1:       dur = near(32'(cfg_now.short_press_max_ms));
            2:       dur = near(32'(cfg_now.long_press_ms));
            3:       dur = $urandom_range(0, 2 * cfg_now.long_press_ms + 100);
            default: dur = $urandom_range(0, 300);
        endcase
        if ($urandom_range(0, 4) == 0) begin
            b = $urandom_range(0, cfg_now.debounce_ms + 2);
            add_sample(1'b0, t0 + b);
            add_sample(1'b1, t0 + b + $urandom_range(0, 5));
        end
        k = $urandom_range(0, 3);
        for (int j = 1; j <= k; j++)
            add_sample(1'b1, t0 + (dur / (k + 1)) * j);
        if ($urandom_range(0, 2) == 0 && cfg_now.long_press_ms < dur)
            add_sample(1'b1, t0 + cfg_now.long_press_ms);
        cur_ms = t0 + dur;
        add_sample(1'b0, cur_ms);
        k = $urandom_range(0, 2);
        for (int j = 0; j < k; j++) begin
            cur_ms = cur_ms + $urandom_range(1, 200);
            add_sample(1'b0, cur_ms);
        end
    endtask

    task automatic run_phase(input int mode, input logic [15:0] deb,
                             input logic [15:0] lng, input logic [15:0] smax);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
        endcase
        cfg_write(bpc_pkg::CFG_DEBOUNCE, deb);
        cfg_write(bpc_pkg::CFG_LONG, lng);
        cfg_write(bpc_pkg::CFG_SHORT_MAX, smax);
        cfg_write(CFG_UNUSED, 16'($urandom()));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_ms = $urandom();
        n_queued = 0;
        while (n_queued < PhaseItems) begin
            if ($urandom_range(0, 9) == 0) begin
                add_sample(1'($urandom_range(0, 1)), $urandom());
                if ($urandom_range(0, 1) == 0)
                    cur_ms = $urandom();
            end else begin
                gen_press();
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default thresholds: debounce 50, long 1000, short max 500
        add_sample(1'b0, 32'd0);
        add_sample(1'b1, 32'd10);          // press too soon after reset release
        add_sample(1'b0, 32'd20);
        add_sample(1'b1, 32'd100);
        add_sample(1'b1, 32'd200);
        add_sample(1'b0, 32'd400);         // short press
        add_sample(1'b1, 32'd420);         // bounce, press ignored
        add_sample(1'b0, 32'd430);         // release with nothing held
        add_sample(1'b1, 32'd600);
        add_sample(1'b1, 32'd1599);
        add_sample(1'b1, 32'd1600);        // long press
        add_sample(1'b1, 32'd1700);
        add_sample(1'b0, 32'd1800);
        add_sample(1'b1, 32'd2000);
        add_sample(1'b0, 32'd2020);        // release too soon, stays held
        add_sample(1'b0, 32'd3100);        // long press fires while released
        add_sample(1'b1, 32'd3200);
        add_sample(1'b0, 32'd3600);
        add_sample(1'b1, 32'd4000);
        add_sample(1'b0, 32'd5000);        // long press and release together
        add_sample(1'b1, 32'hFFFF_FFF0);
        add_sample(1'b0, 32'h0000_0100);   // short press across the wrap
        add_sample(1'b1, 32'h0000_0180);
        add_sample(1'b1, 32'h0000_0170);   // time going backwards
        add_sample(1'b0, 32'h0000_0150);
        wait_drained();

        run_phase(0, 16'd50,    16'd1000,  16'd500);
        run_phase(1, 16'd0,     16'd0,     16'd0);
        run_phase(2, 16'd65535, 16'd65535, 16'd65535);
        run_phase(3, 16'd0,     16'd65535, 16'd65535);
        run_phase(0, 16'd65535, 16'd0,     16'd1);
        run_phase(1, 16'($urandom_range(1, 100)), 16'($urandom_range(100, 600)),
                  16'($urandom_range(50, 800)));
        run_phase(2, 16'($urandom()), 16'($urandom()), 16'($urandom()));
        run_phase(3, 16'd3,     16'd20,    16'd10);

        wait_drained();
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
